/* design/pifc_pkg.sv */
// ----------------------------------------------------------------------------
// pifc_pkg
// Shared types and constants of the point-in-frustum coverage test.
// ----------------------------------------------------------------------------
package pifc_pkg;

  localparam int MAX_FRUSTA  = 256;
  localparam int COORD_BITS  = 24;
  localparam int VERTS_PER   = 5;
  localparam int NUM_FACES   = 6;
  localparam int STORE_DEPTH = MAX_FRUSTA * VERTS_PER;

  localparam int FSLOT_W = 8;
  localparam int VSLOT_W = 3;
  localparam int CNT_W   = 9;
  localparam int FIDX_W  = $clog2(MAX_FRUSTA);
  localparam int FCNT_W  = $clog2(MAX_FRUSTA + 1);
  localparam int ADDR_W  = $clog2(STORE_DEPTH);

  // determinant datapath widths
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int COF_W  = PROD_W + 1;
  localparam int LO_W   = COF_W - DIFF_W;
  localparam int AL_W   = DIFF_W + LO_W + 1;
  localparam int DET_W  = DIFF_W + COF_W + 1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  // vertex indices of the triangular faces, three per face
  localparam logic [2:0] FACE_TAB [NUM_FACES*3] = '{
    3'd2, 3'd1, 3'd0,
    3'd4, 3'd2, 3'd0,
    3'd3, 3'd4, 3'd0,
    3'd1, 3'd3, 3'd0,
    3'd1, 3'd2, 3'd3,
    3'd3, 3'd2, 3'd4
  };

  // classified beat passed from front to back
  typedef struct packed {
    logic                         is_query;
    logic [ADDR_W-1:0]            addr;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } item_t;

endpackage

/* design/pifc_intf.sv */
// ----------------------------------------------------------------------------
// pifc channel interfaces
// Valid/ready channels for sample and vertex beats and for test results.
// ----------------------------------------------------------------------------
interface pifc_in_if import pifc_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [FSLOT_W-1:0]           frustum_slot;
  logic [VSLOT_W-1:0]           vertex_slot;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;

  modport source (output valid, action, frustum_slot, vertex_slot,
                  coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, action, frustum_slot, vertex_slot,
                  coord_x, coord_y, coord_z, output ready);
endinterface

interface pifc_out_if import pifc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               inside_res;
  logic [FSLOT_W-1:0] first_frustum;

  modport source (output valid, inside_res, first_frustum, input ready);
  modport sink   (input valid, inside_res, first_frustum, output ready);
endinterface

/* design/pifc_front.sv */
// ----------------------------------------------------------------------------
// pifc_front
// Accepts input beats, drops loads to nonexistent slots, forms store address.
// ----------------------------------------------------------------------------
module pifc_front import pifc_pkg::*; (
  pifc_in_if.sink in_i,
  input  logic    q_full_i,
  output logic    q_push_o,
  output item_t   q_item_o
);

  logic slot_ok;

  assign in_i.ready = !q_full_i;

  always_comb begin
    slot_ok = (in_i.vertex_slot < VSLOT_W'(VERTS_PER)) &&
              ({1'b0, in_i.frustum_slot} < CNT_W'(MAX_FRUSTA));
    q_item_o.is_query = (in_i.action == ACT_QUERY);
    q_item_o.addr     = ADDR_W'(ADDR_W'(in_i.frustum_slot) * ADDR_W'(VERTS_PER))
                        + ADDR_W'(in_i.vertex_slot);
    q_item_o.x        = in_i.coord_x;
    q_item_o.y        = in_i.coord_y;
    q_item_o.z        = in_i.coord_z;
  end

  assign q_push_o = in_i.valid && !q_full_i &&
                    (q_item_o.is_query || slot_ok);

endmodule

/* design/pifc_fifo.sv */
// ----------------------------------------------------------------------------
// pifc_fifo
// Short queue of classified beats between front and back.
// ----------------------------------------------------------------------------
module pifc_fifo import pifc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t             slots_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = slots_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= QPTR_W'(wr_q + 1'b1);
      if (pop_i)  rd_q <= QPTR_W'(rd_q + 1'b1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_q] <= item_i;
  end

endmodule

/* design/pifc_back.sv */
// ----------------------------------------------------------------------------
// pifc_back
// Vertex store and sequencer that walks frusta and evaluates face determinants.
// ----------------------------------------------------------------------------
module pifc_back import pifc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CNT_W-1:0] frustum_count_i,
  input  logic             q_valid_i,
  input  item_t            q_item_i,
  output logic             q_pop_o,
  pifc_out_if.source       out_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_ROW, S_P1, S_COF, S_P2, S_TERM, S_SUM, S_DONE
  } state_e;

  state_e            state_q;
  logic [2:0]        k_q;
  logic [2:0]        face_q;
  logic [1:0]        row_q;
  logic [FCNT_W-1:0] f_q;
  logic [FCNT_W-1:0] n_lim;
  logic              found_q;
  logic              res_valid_q;
  logic              res_inside_q;
  logic [FSLOT_W-1:0] res_first_q;

  // vertex store, x/y/z side by side
  logic [3*COORD_BITS-1:0] mem [STORE_DEPTH];
  logic [3*COORD_BITS-1:0] rd_q;
  logic [ADDR_W-1:0]       rd_addr;
  logic                    mem_we;

  logic signed [COORD_BITS-1:0] px_q, py_q, pz_q;
  logic signed [DIFF_W-1:0] dx_q [VERTS_PER];
  logic signed [DIFF_W-1:0] dy_q [VERTS_PER];
  logic signed [DIFF_W-1:0] dz_q [VERTS_PER];
  logic signed [DIFF_W-1:0] mx_q [3];
  logic signed [DIFF_W-1:0] my_q [3];
  logic signed [DIFF_W-1:0] mz_q [3];
  logic signed [PROD_W-1:0] ei_q, fh_q, fg_q, di_q, dh_q, eg_q;
  logic signed [COF_W-1:0]  c1_q, c2_q, c3_q;
  logic signed [PROD_W-1:0] ah_q, bh_q, ch_q;
  logic signed [AL_W-1:0]   al_q, bl_q, cl_q;
  logic signed [DET_W-1:0]  t0_q, t1_q, t2_q;
  logic signed [DET_W-1:0]  det;

  logic [2:0]              sel_v;
  logic [4:0]              tab_idx;
  logic signed [DIFF_W-1:0] vx, vy, vz;
  logic                    out_fire;

  assign n_lim = (frustum_count_i > CNT_W'(MAX_FRUSTA)) ? FCNT_W'(MAX_FRUSTA)
                                                        : FCNT_W'(frustum_count_i);
  assign q_pop_o  = (state_q == S_IDLE) && q_valid_i;
  assign mem_we   = q_pop_o && !q_item_i.is_query;
  assign rd_addr  = ADDR_W'(ADDR_W'(f_q[FIDX_W-1:0]) * ADDR_W'(VERTS_PER))
                    + ADDR_W'(k_q);
  assign out_fire = res_valid_q && out_o.ready;

  assign out_o.valid         = res_valid_q;
  assign out_o.inside_res    = res_inside_q;
  assign out_o.first_frustum = res_first_q;

  always_comb begin
    tab_idx = 5'(5'(face_q) * 5'd3) + 5'(row_q);
    sel_v   = FACE_TAB[tab_idx];
    vx      = dx_q[sel_v];
    vy      = dy_q[sel_v];
    vz      = dz_q[sel_v];
    det     = t0_q + t1_q + t2_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[q_item_i.addr] <= {q_item_i.x, q_item_i.y, q_item_i.z};
    rd_q <= mem[rd_addr];
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        px_q <= q_item_i.x;
        py_q <= q_item_i.y;
        pz_q <= q_item_i.z;
      end
      S_FETCH: begin
        if (k_q != 3'd0) begin
          dx_q[k_q - 3'd1] <= DIFF_W'($signed(rd_q[3*COORD_BITS-1 -: COORD_BITS]))
                              - DIFF_W'(px_q);
          dy_q[k_q - 3'd1] <= DIFF_W'($signed(rd_q[2*COORD_BITS-1 -: COORD_BITS]))
                              - DIFF_W'(py_q);
          dz_q[k_q - 3'd1] <= DIFF_W'($signed(rd_q[COORD_BITS-1:0]))
                              - DIFF_W'(pz_q);
        end
      end
      S_ROW: begin
        mx_q[row_q] <= vx;
        my_q[row_q] <= vy;
        mz_q[row_q] <= vz;
      end
      S_P1: begin
        // 2x2 minors of rows one and two
        ei_q <= my_q[1] * mz_q[2];
        fh_q <= mz_q[1] * my_q[2];
        fg_q <= mz_q[1] * mx_q[2];
        di_q <= mx_q[1] * mz_q[2];
        dh_q <= mx_q[1] * my_q[2];
        eg_q <= my_q[1] * mx_q[2];
      end
      S_COF: begin
        c1_q <= COF_W'(ei_q) - COF_W'(fh_q);
        c2_q <= COF_W'(fg_q) - COF_W'(di_q);
        c3_q <= COF_W'(dh_q) - COF_W'(eg_q);
      end
      S_P2: begin
        // cofactor split into signed high and unsigned low halves
        ah_q <= mx_q[0] * $signed(c1_q[COF_W-1:LO_W]);
        bh_q <= my_q[0] * $signed(c2_q[COF_W-1:LO_W]);
        ch_q <= mz_q[0] * $signed(c3_q[COF_W-1:LO_W]);
        al_q <= mx_q[0] * $signed({1'b0, c1_q[LO_W-1:0]});
        bl_q <= my_q[0] * $signed({1'b0, c2_q[LO_W-1:0]});
        cl_q <= mz_q[0] * $signed({1'b0, c3_q[LO_W-1:0]});
      end
      S_TERM: begin
        t0_q <= (DET_W'(ah_q) <<< LO_W) + DET_W'(al_q);
        t1_q <= (DET_W'(bh_q) <<< LO_W) + DET_W'(bl_q);
        t2_q <= (DET_W'(ch_q) <<< LO_W) + DET_W'(cl_q);
      end
      default: ;
    endcase
  end

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      k_q          <= '0;
      face_q       <= '0;
      row_q        <= '0;
      f_q          <= '0;
      found_q      <= 1'b0;
      res_valid_q  <= 1'b0;
      res_inside_q <= 1'b0;
      res_first_q  <= '0;
    end else begin
      if (state_q == S_DONE && (!res_valid_q || out_o.ready)) begin
        res_valid_q <= 1'b1;
      end else if (out_fire) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (q_valid_i && q_item_i.is_query) begin
            f_q     <= '0;
            k_q     <= '0;
            found_q <= 1'b0;
            state_q <= (n_lim == '0) ? S_DONE : S_FETCH;
          end
        end
        S_FETCH: begin
          if (k_q == 3'(VERTS_PER)) begin
            face_q  <= '0;
            row_q   <= '0;
            state_q <= S_ROW;
          end else begin
            k_q <= k_q + 3'd1;
          end
        end
        S_ROW: begin
          if (row_q == 2'd2) state_q <= S_P1;
          row_q <= (row_q == 2'd2) ? 2'd0 : row_q + 2'd1;
        end
        S_P1:   state_q <= S_COF;
        S_COF:  state_q <= S_P2;
        S_P2:   state_q <= S_TERM;
        S_TERM: state_q <= S_SUM;
        S_SUM: begin
          if (det[DET_W-1]) begin
            // face sees the point outside: next frustum
            k_q <= '0;
            f_q <= f_q + 1'b1;
            state_q <= (f_q + 1'b1 == n_lim) ? S_DONE : S_FETCH;
          end else if (face_q == 3'(NUM_FACES - 1)) begin
            found_q <= 1'b1;
            state_q <= S_DONE;
          end else begin
            face_q  <= face_q + 3'd1;
            state_q <= S_ROW;
          end
        end
        S_DONE: begin
          if (!res_valid_q || out_o.ready) begin
            res_inside_q <= found_q;
            res_first_q  <= found_q ? FSLOT_W'(f_q) : '0;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/point_in_frustum_coverage_test_unit.sv */
// ----------------------------------------------------------------------------
// point_in_frustum_coverage_test_unit
// Tests sample points against a store of view pyramids by signed volumes.
// ----------------------------------------------------------------------------
//  channel  dir  contents
//  in_i     in   action, frustum_slot, vertex_slot, coord_x/y/z
//  out_o    out  inside_res, first_frustum (one beat per query)
//  cfg      in   cfg_we_i, cfg_data_i -> frustum_count
//
// a load beat is written to the store when the back end is idle. a query
// fetches the vertices of each frustum visited from the store and tests up
// to 6 faces on the shared determinant sequencer, one face at a time. the
// two-entry queue accepts beats until full, also while the back end works
// and while a result waits on out_o. the store has no reset; frustum_count
// resets to 0.
// ----------------------------------------------------------------------------
module point_in_frustum_coverage_test_unit import pifc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_data_i,
  pifc_in_if.sink          in_i,
  pifc_out_if.source       out_o
);

  logic [CNT_W-1:0] frustum_count_q;
  logic             q_push, q_full, q_pop, q_valid;
  item_t            push_item, head_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frustum_count_q <= '0;
    end else if (cfg_we_i) begin
      frustum_count_q <= cfg_data_i;
    end
  end

  pifc_front u_front (
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_item_o (push_item)
  );

  pifc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  pifc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .frustum_count_i (frustum_count_q),
    .q_valid_i       (q_valid),
    .q_item_i        (head_item),
    .q_pop_o         (q_pop),
    .out_o           (out_o)
  );

endmodule
